@@ rtl/pea_pkg.sv @@
// Shared types and constants of the polyphonic envelope allocator.
package pea_pkg;

    // Input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_NOTE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_ATTACK_RATE   = 2'd0;
    localparam logic [1:0] CFG_HOLD_SAMPLES  = 2'd1;
    localparam logic [1:0] CFG_RELEASE_COEF  = 2'd2;
    localparam logic [1:0] CFG_RELEASE_FLOOR = 2'd3;

    // Configuration reset values
    localparam logic [23:0] RST_ATTACK_RATE   = 24'd2689;
    localparam logic [19:0] RST_HOLD_SAMPLES  = 20'd134400;
    localparam logic [23:0] RST_RELEASE_COEF  = 24'd499;
    localparam logic [15:0] RST_RELEASE_FLOOR = 16'd168;

    // Fixed-point constants
    localparam logic [18:0] MIN_FREQ         = 19'd320;     // 20 Hz in 1/16 Hz
    localparam logic [16:0] AMP_ONE          = 17'd65536;   // 1.0 in Q1.16
    localparam logic [24:0] NOTE_START_LEVEL = 25'd1678;    // 0.0001 in Q1.24

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_HOLD    = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_TICK,
        S_DONE
    } t_state;

    // State of one voice, held in one cell
    typedef struct packed {
        t_phase      phase;
        logic [24:0] level;
        logic [16:0] peak;
        logic [24:0] step;
        logic [19:0] hold;
    } t_voice;

    typedef struct packed {
        logic [23:0] attack_rate;
        logic [19:0] hold_samples;
        logic [23:0] release_coef;
        logic [15:0] release_floor;
    } t_cfg;

    // Control from the sequencer to the voice update unit
    typedef struct packed {
        logic tick;
        logic apply;
    } t_head_ctl;

    typedef struct packed {
        logic        cmd;
        logic [18:0] frequency;
        logic [16:0] amplitude;
    } t_in;

    typedef struct packed {
        logic [24:0] level_voice0;
        logic [24:0] level_voice1;
        logic [24:0] level_voice2;
        logic [1:0]  phase_voice0;
        logic [1:0]  phase_voice1;
        logic [1:0]  phase_voice2;
        logic [1:0]  active_count;
        logic        note_taken;
        logic [1:0]  note_voice;
    } t_out;

endpackage

@@ rtl/pea_cell.sv @@
// One voice cell of the rotating chain: holds a voice and passes it on.
module pea_cell
    import pea_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_voice i_voice,
    output t_voice o_voice,
    output logic   o_active
);

    t_voice r_voice;

    // Take the neighbor's voice whenever the chain rotates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice <= '0;
        end else if (i_shift) begin
            r_voice <= i_voice;
        end
    end

    assign o_voice  = r_voice;
    assign o_active = (r_voice.phase != PH_IDLE);

endmodule

@@ rtl/pea_voice_step.sv @@
// Voice update unit at the head of the chain: tick step or note start.
module pea_voice_step
    import pea_pkg::*;
(
    input  t_voice      i_voice,
    input  t_head_ctl   i_ctl,
    input  t_cfg        i_cfg,
    input  logic [16:0] i_note_peak,
    input  logic [24:0] i_note_step,
    output t_voice      o_voice
);

    logic [25:0] att_sum;
    logic [24:0] att_peak;
    logic [48:0] rel_prod;
    logic [49:0] rel_round;
    logic [25:0] rel_dec;
    logic [24:0] rel_level;

    // Attack: linear step, clamped at the peak
    assign att_sum  = {1'b0, i_voice.level} + {1'b0, i_voice.step};
    assign att_peak = {i_voice.peak, 8'd0};

    // Release: remove a rounded fraction of the level
    assign rel_prod  = 49'(i_cfg.release_coef) * 49'(i_voice.level);
    assign rel_round = {1'b0, rel_prod} + 50'h80_0000;
    assign rel_dec   = rel_round[49:24];
    assign rel_level = (rel_dec >= {1'b0, i_voice.level}) ? 25'd0
                     : i_voice.level - rel_dec[24:0];

    always_comb begin
        o_voice = i_voice;
        if (i_ctl.apply) begin
            o_voice.phase = PH_ATTACK;
            o_voice.level = NOTE_START_LEVEL;
            o_voice.peak  = i_note_peak;
            o_voice.step  = i_note_step;
            o_voice.hold  = i_cfg.hold_samples;
        end else if (i_ctl.tick) begin
            case (i_voice.phase)
                PH_ATTACK: begin
                    if (att_sum >= {1'b0, att_peak}) begin
                        o_voice.level = att_peak;
                        o_voice.phase = PH_HOLD;
                    end else begin
                        o_voice.level = att_sum[24:0];
                    end
                end
                PH_HOLD: begin
                    if (i_voice.hold <= 20'd1) begin
                        o_voice.hold  = 20'd0;
                        o_voice.phase = PH_RELEASE;
                    end else begin
                        o_voice.hold = i_voice.hold - 20'd1;
                    end
                end
                PH_RELEASE: begin
                    if (rel_level <= {9'd0, i_cfg.release_floor}) begin
                        o_voice.level = 25'd0;
                        o_voice.phase = PH_IDLE;
                    end else begin
                        o_voice.level = rel_level;
                    end
                end
                default: begin
                    o_voice = i_voice;
                end
            endcase
        end
    end

endmodule

@@ rtl/polyphonic_envelope_allocator.sv @@
// Top level of the polyphonic envelope allocator: voice chain and sequencer.
// The voices live in a ring of VOICE_COUNT cells that rotates one place per
// cycle while an item is worked on, through a single update unit, so every
// tick or accepted note walks all voices in index order. A tick makes one
// rotation; an accepted note makes two (one rotation to pick the voice, one
// to start it); a note below 20 Hz makes none. The result sits in an output
// register, so the next item is taken while it waits; the block holds in its
// last cycle only if the previous result is still untaken. Configuration
// writes are registered, with no read-back.
module polyphonic_envelope_allocator
    import pea_pkg::*;
#(
    parameter int VOICE_COUNT = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CW = $clog2(VOICE_COUNT + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(VOICE_COUNT - 1);

    t_state      r_state, n_state;
    logic [IW-1:0] r_k;
    logic [16:0] r_amp;
    logic [24:0] r_note_step;
    logic        r_found_idle;
    logic [IW-1:0] r_best;
    logic [24:0] r_best_level;
    logic        r_taken;
    logic        r_out_valid;
    t_out        r_out;
    t_cfg        r_cfg;

    logic        w_in_xfer;
    logic        w_out_free;
    logic        w_last;
    logic        w_rotate;
    logic        w_load_out;
    logic        w_note_ok;
    t_head_ctl   w_ctl;
    t_voice      w_head_out;
    t_voice      w_voice  [VOICE_COUNT];
    logic        w_active [VOICE_COUNT];
    logic [40:0] w_step_prod;
    logic [41:0] w_step_round;
    logic [24:0] w_show_level [3];
    logic [1:0]  w_show_phase [3];
    logic [CW-1:0] w_count;
    t_out        n_out;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_last     = (r_k == LAST_IDX);
    assign w_note_ok  = (i_in_data.frequency >= MIN_FREQ);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_rate   <= RST_ATTACK_RATE;
            r_cfg.hold_samples  <= RST_HOLD_SAMPLES;
            r_cfg.release_coef  <= RST_RELEASE_COEF;
            r_cfg.release_floor <= RST_RELEASE_FLOOR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ATTACK_RATE:   r_cfg.attack_rate   <= i_cfg_data;
                CFG_HOLD_SAMPLES:  r_cfg.hold_samples  <= i_cfg_data[19:0];
                CFG_RELEASE_COEF:  r_cfg.release_coef  <= i_cfg_data;
                CFG_RELEASE_FLOOR: r_cfg.release_floor <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (i_in_data.cmd == CMD_TICK) n_state = S_TICK;
                    else if (w_note_ok)            n_state = S_SCAN;
                    else                           n_state = S_DONE;
                end
            end
            S_SCAN:  if (w_last) n_state = S_APPLY;
            S_APPLY: if (w_last) n_state = S_DONE;
            S_TICK:  if (w_last) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_rotate   = 1'b0;
        w_load_out = 1'b0;
        w_ctl      = '0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_SCAN:  w_rotate = 1'b1;
            S_APPLY: begin
                w_rotate    = 1'b1;
                w_ctl.apply = (r_k == r_best);
            end
            S_TICK: begin
                w_rotate   = 1'b1;
                w_ctl.tick = 1'b1;
            end
            S_DONE:  w_load_out = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (!w_rotate || w_last) r_k <= '0;
            else                     r_k <= r_k + IW'(1);
        end
    end

    // Note parameters: saturated peak and rounded attack step
    assign w_step_prod  = 41'(r_amp) * 41'(r_cfg.attack_rate);
    assign w_step_round = {1'b0, w_step_prod} + 42'h8000;

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_amp   <= (i_in_data.amplitude > AMP_ONE) ? AMP_ONE : i_in_data.amplitude;
            r_taken <= (i_in_data.cmd == CMD_NOTE) && w_note_ok;
        end
        r_note_step <= w_step_round[40:16];
    end

    // Voice pick: first idle voice, else lowest level, earliest on ties
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            if (r_k == '0) begin
                r_found_idle <= (w_voice[0].phase == PH_IDLE);
                r_best       <= '0;
                r_best_level <= w_voice[0].level;
            end else if (!r_found_idle) begin
                if (w_voice[0].phase == PH_IDLE) begin
                    r_found_idle <= 1'b1;
                    r_best       <= r_k;
                end else if (w_voice[0].level < r_best_level) begin
                    r_best       <= r_k;
                    r_best_level <= w_voice[0].level;
                end
            end
        end
    end

    // Update unit between cell 0 and the last cell
    pea_voice_step u_step (
        .i_voice     (w_voice[0]),
        .i_ctl       (w_ctl),
        .i_cfg       (r_cfg),
        .i_note_peak (r_amp),
        .i_note_step (r_note_step),
        .o_voice     (w_head_out)
    );

    // Cell chain: cell g takes from cell g+1, the last cell from the unit
    for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_cell
        t_voice w_in_voice;
        if (g == VOICE_COUNT - 1) begin : g_tail
            assign w_in_voice = w_head_out;
        end else begin : g_mid
            assign w_in_voice = w_voice[g+1];
        end
        pea_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_rotate),
            .i_voice  (w_in_voice),
            .o_voice  (w_voice[g]),
            .o_active (w_active[g])
        );
    end

    // Shown voices; missing ones read as idle at zero
    for (genvar s = 0; s < 3; s++) begin : g_show
        if (s < VOICE_COUNT) begin : g_have
            assign w_show_level[s] = w_voice[s].level;
            assign w_show_phase[s] = w_voice[s].phase;
        end else begin : g_none
            assign w_show_level[s] = 25'd0;
            assign w_show_phase[s] = 2'd0;
        end
    end

    // Result assembly
    always_comb begin
        w_count = '0;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            if (w_active[v]) w_count = w_count + CW'(1);
        end
        n_out.level_voice0 = w_show_level[0];
        n_out.level_voice1 = w_show_level[1];
        n_out.level_voice2 = w_show_level[2];
        n_out.phase_voice0 = w_show_phase[0];
        n_out.phase_voice1 = w_show_phase[1];
        n_out.phase_voice2 = w_show_phase[2];
        n_out.active_count = (4'(w_count) >= 4'd3) ? 2'd3 : 2'(w_count);
        n_out.note_taken   = r_taken;
        n_out.note_voice   = r_taken ? 2'(r_best) : 2'd0;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/pea_checker.sv @@
// Port-level checks of the envelope allocator, bound to the top level.
module pea_checker
    import pea_pkg::*;
#(
    parameter int VOICE_COUNT = 3
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out        o_out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // No voice index without a started note
    a_voice_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.note_taken |-> o_out_data.note_voice == 2'd0)
        else $error("note_voice set without a started note");

    // A started voice 0 shows attack at the start level
    a_note_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.note_taken && o_out_data.note_voice == 2'd0
        && VOICE_COUNT <= 4
        |-> o_out_data.phase_voice0 == PH_ATTACK
            && o_out_data.level_voice0 == NOTE_START_LEVEL)
        else $error("started voice 0 not in attack at start level");

    // An idle voice 0 sits at zero level
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.phase_voice0 == PH_IDLE
        |-> o_out_data.level_voice0 == 25'd0)
        else $error("idle voice 0 with nonzero level");

    // With three voices the count matches the shown phases
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && VOICE_COUNT == 3
        |-> o_out_data.active_count == 2'(o_out_data.phase_voice0 != 2'd0)
            + 2'(o_out_data.phase_voice1 != 2'd0)
            + 2'(o_out_data.phase_voice2 != 2'd0))
        else $error("active_count disagrees with voice phases");

endmodule

bind polyphonic_envelope_allocator pea_checker #(.VOICE_COUNT(VOICE_COUNT)) u_pea_checker (.*);
